// File: hdl/stk_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants for the streaming top-k selector.
package stk_pkg;

   localparam int DATA_WIDTH = 32;

   // Operation applied to every cell of the chain at once
   typedef enum logic [1:0] {
      CELL_HOLD  = 2'd0,
      CELL_GROW  = 2'd1,
      CELL_SLIDE = 2'd2,
      CELL_DRAIN = 2'd3
   } stk_op_type;

   // What one cell shows its neighbors
   typedef struct packed {
      logic signed [DATA_WIDTH-1:0] value;
      logic                         valid;
      logic                         greater;
   } stk_link_type;

endpackage

// File: hdl/streaming_top_k_selector.sv
`timescale 1ns / 1ps
// Throughput: one input item per cycle while a set is filling; the sorted cell chain
//   compares every cell against the new value in parallel.
// Output: the item with end_of_set is stored in its cycle; results are then registered
//   from the chain head, one result per cycle while the receiver takes them, as the
//   chain shifts down. A set of n kept values (n <= TOP_COUNT) blocks input while it
//   drains, and it stays in drain while the receiver stalls a waiting result.
// Reset (synchronous, active high) empties the chain and the output register.
module streaming_top_k_selector #(
   parameter int TOP_COUNT = 10
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_valid,
   output logic                                 req_ready,
   input  logic signed [stk_pkg::DATA_WIDTH-1:0] req_sample_value,
   input  logic                                 req_end_of_set,
   output logic                                 rsp_valid,
   input  logic                                 rsp_ready,
   output logic signed [stk_pkg::DATA_WIDTH-1:0] rsp_top_value,
   output logic                                 rsp_run_end
);
   import stk_pkg::*;

   typedef enum logic [1:0] {
      ST_FILL  = 2'b01,
      ST_DRAIN = 2'b10
   } state_type;

   state_type                    state_ff, state_in;
   stk_op_type                   op;
   stk_link_type                 link [TOP_COUNT];
   logic [TOP_COUNT-1:0]         valid_vec;
   logic                         accept;
   logic                         load;
   logic                         last_w;
   logic                         rsp_valid_ff, rsp_valid_in;
   logic signed [DATA_WIDTH-1:0] rsp_value_ff, rsp_value_in;
   logic                         rsp_end_ff, rsp_end_in;

   assign req_ready     = (state_ff == ST_FILL);
   assign accept        = req_valid && req_ready;
   assign load          = (state_ff == ST_DRAIN) && (!rsp_valid_ff || rsp_ready);
   assign rsp_valid     = rsp_valid_ff;
   assign rsp_top_value = rsp_value_ff;
   assign rsp_run_end   = rsp_end_ff;

   // Chain of cells, boundaries act as -infinity below and +infinity above
   generate
      for (genvar i = 0; i < TOP_COUNT; i++) begin : g_cell
         stk_link_type lower_w, upper_w;
         if (i == 0) begin : g_lo_edge
            assign lower_w = '{value: '0, valid: 1'b1, greater: 1'b0};
         end else begin : g_lo
            assign lower_w = link[i-1];
         end
         if (i == TOP_COUNT - 1) begin : g_hi_edge
            assign upper_w = '{value: '0, valid: 1'b0, greater: 1'b1};
         end else begin : g_hi
            assign upper_w = link[i+1];
         end
         stk_cell u_cell (
            .clock  (clock),
            .reset  (reset),
            .op     (op),
            .sample (req_sample_value),
            .lower  (lower_w),
            .upper  (upper_w),
            .link   (link[i])
         );
         assign valid_vec[i] = link[i].valid;
      end
      // last result when the cell above the head is empty
      if (TOP_COUNT == 1) begin : g_last_one
         assign last_w = 1'b1;
      end else begin : g_last
         assign last_w = !link[1].valid;
      end
   endgenerate

   // Chain operation for this cycle
   always_comb begin
      op = CELL_HOLD;
      if (accept) begin
         if (!link[TOP_COUNT-1].valid) begin
            op = CELL_GROW;
         end else if (req_sample_value > link[0].value) begin
            op = CELL_SLIDE;
         end
      end else if (load) begin
         op = CELL_DRAIN;
      end
   end

   // Sequencer and output register
   always_comb begin
      state_in     = state_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_value_in = rsp_value_ff;
      rsp_end_in   = rsp_end_ff;
      if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
      case (state_ff)
         ST_FILL: begin
            if (accept && req_end_of_set) begin
               state_in = ST_DRAIN;
            end
         end
         ST_DRAIN: begin
            if (load) begin
               rsp_valid_in = 1'b1;
               rsp_value_in = link[0].value;
               rsp_end_in   = last_w;
               if (last_w) begin
                  state_in = ST_FILL;
               end
            end
         end
         default: begin
            state_in = ST_FILL;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_FILL;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      rsp_value_ff <= rsp_value_in;
      rsp_end_ff   <= rsp_end_in;
   end

`ifndef SYNTHESIS
   // kept entries always occupy the bottom of the chain
   a_valid_packed: assert property (@(posedge clock) disable iff (reset)
      ((valid_vec + {{(TOP_COUNT-1){1'b0}}, 1'b1}) & valid_vec) == '0)
      else $error("valid cells not contiguous from the bottom");

   // a drain never starts or continues on an empty chain
   a_drain_nonempty: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_DRAIN) |-> link[0].valid)
      else $error("draining an empty chain");

   // the ending item moves the block into drain
   a_end_starts_drain: assert property (@(posedge clock) disable iff (reset)
      (accept && req_end_of_set) |=> (state_ff == ST_DRAIN))
      else $error("end of set did not start drain");

   // once the last result is loaded the chain is empty
   a_drain_clears: assert property (@(posedge clock) disable iff (reset)
      (load && last_w) |=> (valid_vec == '0) && (state_ff == ST_FILL))
      else $error("store not cleared after run");
`endif

endmodule

// File: hdl/stk_cell.sv
`timescale 1ns / 1ps
// One cell of the sorted insertion chain: holds a single kept value.
module stk_cell (
   input  logic                                 clock,
   input  logic                                 reset,
   input  stk_pkg::stk_op_type                  op,
   input  logic signed [stk_pkg::DATA_WIDTH-1:0] sample,
   input  stk_pkg::stk_link_type                lower,
   input  stk_pkg::stk_link_type                upper,
   output stk_pkg::stk_link_type                link
);
   import stk_pkg::*;

   logic signed [DATA_WIDTH-1:0] value_ff, value_in;
   logic                         valid_ff, valid_in;
   logic                         greater;

   // Empty cells act as +infinity so a growing insert larger than every kept value lands at the fill edge
   assign greater = !valid_ff || (value_ff > sample);

   assign link.value   = value_ff;
   assign link.valid   = valid_ff;
   assign link.greater = greater;

   // Next value from own compare and the neighbors' compares
   always_comb begin
      value_in = value_ff;
      valid_in = valid_ff;
      case (op)
         CELL_GROW: begin
            // shift larger entries up by one, new value goes below them
            if (lower.greater) begin
               value_in = lower.value;
            end else if (greater) begin
               value_in = sample;
            end
            valid_in = valid_ff | lower.valid;
         end
         CELL_SLIDE: begin
            // full store: smallest drops out, entries not above sample move down
            if (!upper.greater) begin
               value_in = upper.value;
            end else if (!greater) begin
               value_in = sample;
            end
         end
         CELL_DRAIN: begin
            value_in = upper.value;
            valid_in = upper.valid;
         end
         default: begin
            value_in = value_ff;
            valid_in = valid_ff;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      value_ff <= value_in;
   end

endmodule
